// ===== hw/rtl/vau_pkg.sv =====
// shared types, rule codes and arithmetic helpers for the value approach unit
package vau_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned AMT_W  = 15;
  localparam int unsigned RES_W  = 17;
  localparam int unsigned WORK_W = 18;
  localparam int unsigned RCP_W  = 12;
  localparam int unsigned PHASE_W = 12;

  localparam logic [OP_W-1:0] OP_EXP2   = 4'd0;
  localparam logic [OP_W-1:0] OP_EXP4   = 4'd1;
  localparam logic [OP_W-1:0] OP_EXP8   = 4'd2;
  localparam logic [OP_W-1:0] OP_PHASE  = 4'd3;
  localparam logic [OP_W-1:0] OP_RANGE  = 4'd4;
  localparam logic [OP_W-1:0] OP_SPEED  = 4'd5;
  localparam logic [OP_W-1:0] OP_TIME   = 4'd6;
  localparam logic [OP_W-1:0] OP_EXP2P  = 4'd7;
  localparam logic [OP_W-1:0] OP_EXP4P  = 4'd8;
  localparam logic [OP_W-1:0] OP_EXP8P  = 4'd9;
  localparam logic [OP_W-1:0] OP_TIMEP  = 4'd10;
  localparam logic [OP_W-1:0] OP_EXP2S  = 4'd11;
  localparam logic [OP_W-1:0] OP_EXP4S  = 4'd12;
  localparam logic [OP_W-1:0] OP_EXP8S  = 4'd13;

  localparam logic [AMT_W-1:0] STEP_MAX = 15'd15;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] current;
    logic signed [VAL_W-1:0] target;
    logic [AMT_W-1:0]        amount;
  } item_t;

  // 4096/(k+1), truncated; entry 0 is 0, which makes the timed step snap to the target
  function automatic logic [RCP_W-1:0] recip(input logic [3:0] idx);
    logic [RCP_W-1:0] r;
    case (idx)
      4'd0:    r = 12'd0;
      4'd1:    r = 12'd2048;
      4'd2:    r = 12'd1365;
      4'd3:    r = 12'd1024;
      4'd4:    r = 12'd819;
      4'd5:    r = 12'd682;
      4'd6:    r = 12'd585;
      4'd7:    r = 12'd512;
      4'd8:    r = 12'd455;
      4'd9:    r = 12'd409;
      4'd10:   r = 12'd372;
      4'd11:   r = 12'd341;
      4'd12:   r = 12'd315;
      4'd13:   r = 12'd292;
      4'd14:   r = 12'd273;
      default: r = 12'd256;
    endcase
    return r;
  endfunction

  // divide by 2^k, truncating toward zero
  function automatic logic signed [WORK_W-1:0] div_pow2(input logic signed [WORK_W-1:0] v,
                                                        input logic [1:0] k);
    logic signed [WORK_W-1:0] bias;
    bias = v[WORK_W-1] ? ((18'sd1 <<< k) - 18'sd1) : 18'sd0;
    return (v + bias) >>> k;
  endfunction

  // unwrap a 12-bit angle toward the target
  function automatic logic signed [WORK_W-1:0] phase_unwrap(input logic signed [WORK_W-1:0] c,
                                                            input logic signed [WORK_W-1:0] t);
    logic signed [WORK_W-1:0] d;
    logic [PHASE_W-1:0]       g12;
    logic signed [WORK_W-1:0] g;
    d   = c - t;
    g12 = d[PHASE_W-1:0];
    g   = $signed({{(WORK_W-PHASE_W){1'b0}}, g12});
    if (g12 > 12'd2048) begin
      g = g - 18'sd4096;
    end
    return t + g;
  endfunction

endpackage

// ===== hw/rtl/vau_step.sv =====
// combinational approach step for one item
module vau_step (
  input  vau_pkg::item_t                     item,
  output logic signed [vau_pkg::RES_W-1:0]   next_value
);

  localparam int unsigned W = vau_pkg::WORK_W;

  logic signed [W-1:0]    cur;
  logic signed [W-1:0]    tgt;
  logic signed [W-1:0]    amt;
  logic signed [W-1:0]    cur_p;
  logic signed [W-1:0]    base;
  logic                   use_phase;
  logic [1:0]             k;
  logic signed [W-1:0]    div;
  logic signed [W-1:0]    gap;
  logic signed [W-1:0]    gdiv;
  logic signed [W-1:0]    exp_res;
  logic signed [W-1:0]    exps_res;
  logic signed [W-1:0]    lo;
  logic signed [W-1:0]    hi;
  logic signed [W-1:0]    range_res;
  logic signed [W-1:0]    nx;
  logic signed [W-1:0]    speed_res;
  logic [3:0]             idx;
  logic [vau_pkg::RCP_W-1:0] rcp;
  logic signed [vau_pkg::RCP_W:0] rcp_s;
  logic signed [30:0]     prod;
  logic signed [30:0]     prod_b;
  logic signed [30:0]     quot;
  logic signed [W-1:0]    time_res;
  logic signed [W-1:0]    res;

  assign cur = W'(item.current);
  assign tgt = W'(item.target);
  assign amt = $signed({{(W-vau_pkg::AMT_W){1'b0}}, item.amount});

  assign cur_p = vau_pkg::phase_unwrap(cur, tgt);
  assign use_phase = (item.op == vau_pkg::OP_EXP2P) || (item.op == vau_pkg::OP_EXP4P) ||
                     (item.op == vau_pkg::OP_EXP8P) || (item.op == vau_pkg::OP_TIMEP);
  assign base = use_phase ? cur_p : cur;

  always_comb begin
    case (item.op)
      vau_pkg::OP_EXP4, vau_pkg::OP_EXP4P, vau_pkg::OP_EXP4S: k = 2'd2;
      vau_pkg::OP_EXP8, vau_pkg::OP_EXP8P, vau_pkg::OP_EXP8S: k = 2'd3;
      default:                                             k = 2'd1;
    endcase
  end

  assign div  = 18'sd1 <<< k;
  assign gap  = tgt - base;
  assign gdiv = vau_pkg::div_pow2(gap, k);

  // snap when the gap is under the divisor
  assign exp_res  = ((gap > -div) && (gap < div)) ? tgt : base + gdiv;
  // snap when the scaled gap is under the speed
  assign exps_res = ((gdiv > -amt) && (gdiv < amt)) ? tgt : base + gdiv;

  assign lo = tgt - amt;
  assign hi = tgt + amt;
  assign range_res = (cur < lo) ? lo : ((cur > hi) ? hi : cur);

  always_comb begin
    if (cur < tgt) begin
      nx = cur + amt;
      speed_res = (nx >= tgt) ? tgt : nx;
    end else begin
      nx = cur - amt;
      speed_res = (nx <= tgt) ? tgt : nx;
    end
  end

  assign idx    = (item.amount > vau_pkg::STEP_MAX) ? 4'd15 : item.amount[3:0];
  assign rcp    = vau_pkg::recip(idx);
  assign rcp_s  = $signed({1'b0, rcp});
  assign prod   = gap * rcp_s;
  assign prod_b = prod[30] ? (prod + 31'sd4095) : prod;
  assign quot   = prod_b >>> 12;
  assign time_res = (rcp == '0) ? tgt : (quot[W-1:0] + base);

  always_comb begin
    case (item.op)
      vau_pkg::OP_EXP2, vau_pkg::OP_EXP4, vau_pkg::OP_EXP8,
      vau_pkg::OP_EXP2P, vau_pkg::OP_EXP4P, vau_pkg::OP_EXP8P: res = exp_res;
      vau_pkg::OP_PHASE:                                      res = cur_p;
      vau_pkg::OP_RANGE:                                      res = range_res;
      vau_pkg::OP_SPEED:                                      res = speed_res;
      vau_pkg::OP_TIME, vau_pkg::OP_TIMEP:                    res = time_res;
      vau_pkg::OP_EXP2S, vau_pkg::OP_EXP4S, vau_pkg::OP_EXP8S: res = exps_res;
      default:                                                res = cur;
    endcase
  end

  assign next_value = res[vau_pkg::RES_W-1:0];

endmodule

// ===== hw/rtl/value_approach_unit_core.sv =====
// value approach unit top level: moves a current value one step toward a target
//
// input channel: in_valid/in_ready with in_op, in_current, in_target, in_amount.
// result channel: out_valid/out_ready with out_next_value, one item per input item.
// the item is captured in an input register; the step logic (phase unwrap, one
// 18x13 multiply for time interpolation, compares and adds) sits between that
// register and the result register.
// out_valid rises once an accepted item has moved from the input register into
// the result register. throughput: one item per cycle while out_ready keeps up,
// set by the two-register pipeline.
// when the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready drops only when both are full.
// reset (rst_n low, synchronous) empties both registers; no other state.
// op codes outside the defined set pass current through unchanged.
module value_approach_unit_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vau_pkg::OP_W-1:0]          in_op,
  input  logic signed [vau_pkg::VAL_W-1:0]  in_current,
  input  logic signed [vau_pkg::VAL_W-1:0]  in_target,
  input  logic [vau_pkg::AMT_W-1:0]         in_amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vau_pkg::RES_W-1:0]  out_next_value
);

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  vau_pkg::item_t                    s1_item_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [vau_pkg::RES_W-1:0]  out_next_value_r;
  logic signed [vau_pkg::RES_W-1:0]  out_next_value_nxt;
  logic                              adv_out;
  logic                              in_take;

  assign adv_out  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv_out;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;

  vau_step u_step (
    .item       (s1_item_r),
    .next_value (out_next_value_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.op      <= in_op;
      s1_item_r.current <= in_current;
      s1_item_r.target  <= in_target;
      s1_item_r.amount  <= in_amount;
    end
    if (adv_out && s1_valid_r) begin
      out_next_value_r <= out_next_value_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_value = out_next_value_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item not held in input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register changed while output stalled");

  a_rose_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item in flight");

  a_unused_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out && (s1_item_r.op > vau_pkg::OP_EXP8S) |=>
    out_next_value_r == {$past(s1_item_r.current[vau_pkg::VAL_W-1]), $past(s1_item_r.current)})
    else $error("unused op did not pass current through");
`endif

endmodule

// ===== dv/value_approach_checker.sv =====
// watches both channels of the value approach unit, predicts each step and compares results
`timescale 1ns / 100ps
module value_approach_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [vau_pkg::OP_W-1:0]         in_op,
  input  logic signed [vau_pkg::VAL_W-1:0] in_current,
  input  logic signed [vau_pkg::VAL_W-1:0] in_target,
  input  logic [vau_pkg::AMT_W-1:0]        in_amount,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [vau_pkg::RES_W-1:0] out_next_value,
  output int                               mismatches,
  output int                               results_due
);

  logic signed [vau_pkg::RES_W-1:0] expected_next[$];
  logic signed [vau_pkg::RES_W-1:0] want;
  int                               result_idx = 0;

  function automatic int step_recip(input int k);
    case (k)
      0:       return 0;
      1:       return 2048;
      2:       return 1365;
      3:       return 1024;
      4:       return 819;
      5:       return 682;
      6:       return 585;
      7:       return 512;
      8:       return 455;
      9:       return 409;
      10:      return 372;
      11:      return 341;
      12:      return 315;
      13:      return 292;
      14:      return 273;
      default: return 256;
    endcase
  endfunction

  function automatic int exp_approach(input int c, input int t, input int div);
    int gap;
    gap = t - c;
    if (gap > -div && gap < div) return t;
    return c + gap / div;
  endfunction

  function automatic int phase_wrap(input int c, input int t);
    int gap;
    gap = (c - t) & 4095;
    if (gap > 2048) gap = gap - 4096;
    return t + gap;
  endfunction

  function automatic int timed_approach(input int c, input int t, input int steps);
    int r;
    if (steps > 15) steps = 15;
    r = step_recip(steps);
    if (r == 0) return t;
    return (t - c) * r / 4096 + c;
  endfunction

  function automatic int scaled_approach(input int c, input int t, input int div, input int s);
    int g;
    g = (t - c) / div;
    if (g > -s && g < s) return t;
    return c + g;
  endfunction

  function automatic logic signed [vau_pkg::RES_W-1:0] predict_next(
    input logic [vau_pkg::OP_W-1:0]         op,
    input logic signed [vau_pkg::VAL_W-1:0] cur_v,
    input logic signed [vau_pkg::VAL_W-1:0] tgt_v,
    input logic [vau_pkg::AMT_W-1:0]        amt_v
  );
    int c;
    int t;
    int a;
    int res;
    c = cur_v;
    t = tgt_v;
    a = amt_v;
    case (op)
      vau_pkg::OP_EXP2:  res = exp_approach(c, t, 2);
      vau_pkg::OP_EXP4:  res = exp_approach(c, t, 4);
      vau_pkg::OP_EXP8:  res = exp_approach(c, t, 8);
      vau_pkg::OP_PHASE: res = phase_wrap(c, t);
      vau_pkg::OP_RANGE: begin
        if (c < t - a) res = t - a;
        else if (c > t + a) res = t + a;
        else res = c;
      end
      vau_pkg::OP_SPEED: begin
        if (c < t) res = (c + a >= t) ? t : c + a;
        else res = (c - a <= t) ? t : c - a;
      end
      vau_pkg::OP_TIME:  res = timed_approach(c, t, a);
      vau_pkg::OP_EXP2P: res = exp_approach(phase_wrap(c, t), t, 2);
      vau_pkg::OP_EXP4P: res = exp_approach(phase_wrap(c, t), t, 4);
      vau_pkg::OP_EXP8P: res = exp_approach(phase_wrap(c, t), t, 8);
      vau_pkg::OP_TIMEP: res = timed_approach(phase_wrap(c, t), t, a);
      vau_pkg::OP_EXP2S: res = scaled_approach(c, t, 2, a);
      vau_pkg::OP_EXP4S: res = scaled_approach(c, t, 4, a);
      vau_pkg::OP_EXP8S: res = scaled_approach(c, t, 8, a);
      default:           res = c;
    endcase
    return res[vau_pkg::RES_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", result_idx, what);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_next.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_next.size() == 0) begin
          report_mismatch($sformatf("unexpected item, next_value %0d", out_next_value));
        end else begin
          want = expected_next.pop_front();
          if (out_next_value !== want) begin
            report_mismatch($sformatf("next_value %0d, expected %0d", out_next_value, want));
          end
        end
        result_idx = result_idx + 1;
      end
      if (in_valid && in_ready) begin
        expected_next.push_back(predict_next(in_op, in_current, in_target, in_amount));
      end
    end
    results_due = expected_next.size();
  end

endmodule

// ===== dv/value_approach_unit_core_test.sv =====
// testbench top for the value approach unit: stimulus, idling phases and verdict
`timescale 1ns / 100ps
module value_approach_unit_core_test;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 125;

  localparam logic [vau_pkg::OP_W-1:0]         OP_SPARE_LO = 4'd14;
  localparam logic [vau_pkg::OP_W-1:0]         OP_SPARE_HI = 4'd15;
  localparam logic signed [vau_pkg::VAL_W-1:0] VAL_MIN     = 16'sh8000;
  localparam logic signed [vau_pkg::VAL_W-1:0] VAL_MAX     = 16'sh7fff;
  localparam logic [vau_pkg::AMT_W-1:0]        AMT_MAX     = 15'h7fff;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [vau_pkg::OP_W-1:0]         in_op = '0;
  logic signed [vau_pkg::VAL_W-1:0] in_current = '0;
  logic signed [vau_pkg::VAL_W-1:0] in_target = '0;
  logic [vau_pkg::AMT_W-1:0]        in_amount = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [vau_pkg::RES_W-1:0] out_next_value;

  int mismatches;
  int results_due;
  int send_idle_pct = 18;
  int recv_idle_pct = 83;
  int quiet_cycles = 0;

  value_approach_unit_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_current     (in_current),
    .in_target      (in_target),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_value (out_next_value)
  );

  value_approach_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_current     (in_current),
    .in_target      (in_target),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_value (out_next_value),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("value_approach_unit_core_test NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(
    input logic [vau_pkg::OP_W-1:0]         op,
    input logic signed [vau_pkg::VAL_W-1:0] cur_v,
    input logic signed [vau_pkg::VAL_W-1:0] tgt_v,
    input logic [vau_pkg::AMT_W-1:0]        amt_v
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_op      = op;
    in_current = cur_v;
    in_target  = tgt_v;
    in_amount  = amt_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [vau_pkg::OP_W-1:0]         op;
    logic signed [vau_pkg::VAL_W-1:0] cur_v;
    logic signed [vau_pkg::VAL_W-1:0] tgt_v;
    logic [vau_pkg::AMT_W-1:0]        amt_v;
    for (int i = 0; i < count; i++) begin
      op    = 4'($urandom_range(15));
      cur_v = 16'($urandom);
      case ($urandom_range(3))
        0: tgt_v = 16'($urandom);
        1: tgt_v = cur_v + 16'($urandom_range(40)) - 16'd20;
        2: tgt_v = cur_v + 16'($urandom_range(8191)) - 16'd4096;
        default: begin
          cur_v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
          tgt_v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
        end
      endcase
      case ($urandom_range(2))
        0: amt_v = 15'($urandom_range(20));
        1: amt_v = 15'($urandom);
        default: amt_v = $urandom_range(1) ? AMT_MAX : 15'd0;
      endcase
      send_item(op, cur_v, tgt_v, amt_v);
    end
  endtask

  // hold off until every result is back
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(vau_pkg::OP_EXP2, VAL_MIN, VAL_MAX, 15'd0);
    send_item(vau_pkg::OP_EXP4, VAL_MAX, VAL_MIN, AMT_MAX);
    send_item(vau_pkg::OP_EXP8, 16'sd5, 16'sd0, 15'd3);
    send_item(vau_pkg::OP_EXP2, 16'sd0, 16'sd1, 15'd0);
    send_item(vau_pkg::OP_PHASE, 16'sd0, 16'sd2048, 15'd0);
    send_item(vau_pkg::OP_PHASE, VAL_MAX, VAL_MIN, AMT_MAX);
    send_item(vau_pkg::OP_RANGE, VAL_MIN, VAL_MAX, AMT_MAX);
    send_item(vau_pkg::OP_RANGE, 16'sd100, 16'sd0, 15'd0);
    send_item(vau_pkg::OP_SPEED, 16'sd0, 16'sd0, 15'd0);
    send_item(vau_pkg::OP_SPEED, 16'sd10, 16'sd20, 15'd0);
    send_item(vau_pkg::OP_SPEED, VAL_MIN, VAL_MAX, AMT_MAX);
    send_item(vau_pkg::OP_TIME, 16'sd100, -16'sd300, 15'd0);
    send_item(vau_pkg::OP_TIME, VAL_MIN, VAL_MAX, 15'd1);
    send_item(vau_pkg::OP_TIME, VAL_MAX, VAL_MIN, AMT_MAX);
    send_item(vau_pkg::OP_TIME, 16'sd7, 16'sd1000, 15'd16);
    send_item(vau_pkg::OP_EXP2P, VAL_MIN, VAL_MAX, 15'd0);
    send_item(vau_pkg::OP_EXP4P, VAL_MAX, VAL_MIN, 15'd0);
    send_item(vau_pkg::OP_EXP8P, 16'sd4000, 16'sd10, 15'd0);
    send_item(vau_pkg::OP_TIMEP, 16'sd3000, -16'sd500, 15'd15);
    send_item(vau_pkg::OP_EXP2S, 16'sd0, 16'sd3, 15'd0);
    send_item(vau_pkg::OP_EXP4S, VAL_MIN, VAL_MAX, AMT_MAX);
    send_item(vau_pkg::OP_EXP8S, 16'sd0, 16'sd7, 15'd1);
    send_item(OP_SPARE_LO, -16'sd1, VAL_MAX, AMT_MAX);
    send_item(OP_SPARE_HI, VAL_MIN, 16'sd0, 15'd0);

    send_random(RANDOM_ITEMS);
    drain_results();

    send_idle_pct = 83;
    recv_idle_pct = 18;
    send_random(RANDOM_ITEMS);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_ITEMS);
    drain_results();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("value_approach_unit_core_test OK");
    end else begin
      $display("value_approach_unit_core_test NOT OK");
    end
    $finish;
  end

endmodule
